// File: design/ekdwh_pkg.sv
package ekdwh_pkg;

    // Hash constants of the splitmix64 finalizer and the key salt.
    localparam logic [63:0] GOLDEN   = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_B    = 64'h94d049bb133111eb;
    localparam logic [63:0] KEY_SALT = 64'hdeadbeefcafebabe;

    // Configuration register indexes.
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] REG_HASH_SEED    = 2'd1;
    localparam logic [1:0] REG_WEIGHT_CAP   = 2'd2;

    // Number of quotient bits, one per divider stage.
    localparam int DIV_STAGES = 64;

    // Pipeline control that travels into the divider.
    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage

// File: design/ekdwh_div.sv
module ekdwh_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ekdwh_pkg::t_pipe_ctl  i_ctl,
    input  logic [63:0]           i_num,
    input  logic [31:0]           i_den,
    output logic                  o_valid,
    output logic [63:0]           o_quo,
    output logic [31:0]           o_rem
);

    localparam int N = ekdwh_pkg::DIV_STAGES;

    logic [31:0] r_rem [0:N-1];
    logic [63:0] r_dq  [0:N-1];
    logic        r_vld [0:N-1];

    // One restoring division step per stage; dividend bits shift out as quotient bits shift in.
    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [31:0] prev_rem;
        logic [63:0] prev_dq;
        logic        prev_vld;
        logic [32:0] trial;
        logic        ge;
        logic [31:0] n_rem;
        logic [63:0] n_dq;

        if (s == 0) begin : g_first
            assign prev_rem = 32'd0;
            assign prev_dq  = i_num;
            assign prev_vld = i_ctl.valid;
        end else begin : g_next
            assign prev_rem = r_rem[s-1];
            assign prev_dq  = r_dq[s-1];
            assign prev_vld = r_vld[s-1];
        end

        always_comb begin
            trial = {prev_rem, prev_dq[63]};
            ge    = (trial >= {1'b0, i_den});
            n_rem = ge ? 32'(trial - {1'b0, i_den}) : trial[31:0];
            n_dq  = {prev_dq[62:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[s] <= prev_vld;
            end
            if (i_ctl.en) begin
                r_rem[s] <= n_rem;
                r_dq[s]  <= n_dq;
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_quo   = r_dq[N-1];
    assign o_rem   = r_rem[N-1];

    // The remainder is always below the divisor.
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rem < i_den))
        else $error("divider remainder not below divisor");

    // A stalled pipeline holds its last stage.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.en |=> ($stable(o_quo) && $stable(o_rem) && $stable(o_valid)))
        else $error("divider output moved during stall");

    // A valid result needs an enabled advance at some edge.
    a_valid_from_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_ctl.en))
        else $error("divider valid rose without advance");

endmodule

// File: design/edge_key_decode_weight_hash.sv
// Pipeline: 5 hash stages, then 64 divider stages, from input transaction to result.
// Throughput: one transaction per cycle unless the output stalls; the 64 one-bit-per-stage divider stages
// for key and hash run side by side, and the whole pipeline stalls as one.
// Reset: synchronous active-low i_rst_n clears all valid bits and sets
// vertex_count to 2, hash_seed to 0 and the weight cap to 1.
module edge_key_decode_weight_hash #(
    parameter int VERTEX_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_edge_key,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_first_vertex,
    output logic [31:0] o_second_vertex,
    output logic [31:0] o_edge_weight,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [31:0] r_vertex_count;
    logic [63:0] r_hash_seed;
    logic [31:0] r_weight_cap;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= 32'd2;
            r_hash_seed    <= 64'd0;
            r_weight_cap   <= 32'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ekdwh_pkg::REG_VERTEX_COUNT: r_vertex_count <= i_cfg_data[31:0];
                ekdwh_pkg::REG_HASH_SEED:    r_hash_seed    <= i_cfg_data;
                ekdwh_pkg::REG_WEIGHT_CAP:   r_weight_cap   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Effective divisors: masked vertex count and max weight, zero read as one.
    logic [31:0] nv;
    logic [31:0] mw;
    always_comb begin
        nv = r_vertex_count & 32'((64'd1 << VERTEX_BITS) - 64'd1);
        if (nv == 32'd0) nv = 32'd1;
        mw = (r_weight_cap == 32'd0) ? 32'd1 : r_weight_cap;
    end

    // The whole pipeline advances when the output is free or being taken.
    logic en;
    logic div_valid;
    assign en      = !div_valid || i_ready;
    assign o_ready = en;

    logic [63:0] r_key [1:5];
    logic        r_v   [1:5];
    logic [63:0] r_z1, r_z3, r_hash;
    logic [63:0] r_pa0, r_pb0;
    logic [31:0] r_pa1, r_pa2, r_pb1, r_pb2;

    logic [63:0] n_z1, n_z2, n_z3, n_z4;
    always_comb begin
        n_z1 = (i_edge_key ^ r_hash_seed ^ ekdwh_pkg::KEY_SALT) + ekdwh_pkg::GOLDEN;
        n_z1 = n_z1 ^ (n_z1 >> 30);
        n_z2 = r_pa0 + {32'(r_pa1 + r_pa2), 32'd0};
        n_z3 = n_z2 ^ (n_z2 >> 27);
        n_z4 = r_pb0 + {32'(r_pb1 + r_pb2), 32'd0};
    end

    // Hash stages; each 64-bit product is split into 32x32 partial products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= 5; i++) r_v[i] <= 1'b0;
        end else if (en) begin
            r_v[1] <= i_valid;
            for (int i = 2; i <= 5; i++) r_v[i] <= r_v[i-1];
        end
        if (en) begin
            r_key[1] <= i_edge_key;
            for (int i = 2; i <= 5; i++) r_key[i] <= r_key[i-1];
            r_z1   <= n_z1;
            r_pa0  <= 64'(r_z1[31:0] * ekdwh_pkg::MIX_A[31:0]);
            r_pa1  <= 32'(r_z1[31:0] * ekdwh_pkg::MIX_A[63:32]);
            r_pa2  <= 32'(r_z1[63:32] * ekdwh_pkg::MIX_A[31:0]);
            r_z3   <= n_z3;
            r_pb0  <= 64'(r_z3[31:0] * ekdwh_pkg::MIX_B[31:0]);
            r_pb1  <= 32'(r_z3[31:0] * ekdwh_pkg::MIX_B[63:32]);
            r_pb2  <= 32'(r_z3[63:32] * ekdwh_pkg::MIX_B[31:0]);
            r_hash <= n_z4 ^ (n_z4 >> 31);
        end
    end

    // The stage-one product feeds r_pa, so r_z1 aligns with r_key[1], the hash with r_key[5].
    ekdwh_pkg::t_pipe_ctl ctl;
    assign ctl = '{en: en, valid: r_v[5]};

    logic [63:0] key_quo, w_quo;
    logic [31:0] key_rem, w_rem;
    logic        w_valid;

    ekdwh_div u_key_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_num   (r_key[5]),
        .i_den   (nv),
        .o_valid (div_valid),
        .o_quo   (key_quo),
        .o_rem   (key_rem)
    );

    ekdwh_div u_weight_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_num   (r_hash),
        .i_den   (mw),
        .o_valid (w_valid),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // Saturate the quotient to VERTEX_BITS bits.
    logic [31:0] sat;
    assign sat = 32'((64'd1 << VERTEX_BITS) - 64'd1);

    assign o_valid         = div_valid;
    assign o_first_vertex  = (|key_quo[63:VERTEX_BITS]) ? sat : key_quo[31:0];
    assign o_second_vertex = key_rem;
    assign o_edge_weight   = w_rem + 32'd1;

    // Both dividers carry the same transactions.
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid == div_valid)
        else $error("divider lanes out of step");

    // The weight is never zero and never above the effective weight cap.
    a_weight_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_edge_weight != 32'd0) && (o_edge_weight <= mw))
        else $error("edge weight out of range");

    // The second vertex is below the vertex count.
    a_second_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_second_vertex < nv))
        else $error("second vertex out of range");

    // The quotient of the weight division is unused; it must hold still during a stall.
    a_weight_quo_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(w_quo))
        else $error("weight quotient moved during stall");

endmodule
